>>> hdl/fpfa_pkg.sv
// Shared types and codes for the fixed-partition fit allocator.
package fpfa_pkg;

   localparam int PARTITIONS_DEF = 64;
   localparam int SIZE_BITS_DEF  = 16;

   localparam int OP_W       = 2;
   localparam int INDEX_W    = 6;
   localparam int AMOUNT_W   = 16;
   localparam int POLICY_W   = 2;
   localparam int COUNT_W    = 7;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
   localparam logic [OP_W-1:0] OP_ALLOC = 2'd1;
   localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

   localparam logic [POLICY_W-1:0] FIT_FIRST = 2'd0;
   localparam logic [POLICY_W-1:0] FIT_NEXT  = 2'd1;
   localparam logic [POLICY_W-1:0] FIT_BEST  = 2'd2;
   localparam logic [POLICY_W-1:0] FIT_WORST = 2'd3;

   // word index of each register (byte address bit 2)
   localparam logic REG_POLICY = 1'b0;
   localparam logic REG_COUNT  = 1'b1;

   localparam logic [POLICY_W-1:0] POLICY_RESET = FIT_FIRST;
   localparam logic [COUNT_W-1:0]  COUNT_RESET  = 7'd1;

   typedef struct packed {
      logic [OP_W-1:0]     op;
      logic [INDEX_W-1:0]  entry_index;
      logic [AMOUNT_W-1:0] amount;
   } req_type;

   typedef struct packed {
      logic                granted;
      logic [INDEX_W-1:0]  chosen_index;
      logic [AMOUNT_W-1:0] remaining_size;
   } rsp_type;

endpackage

>>> hdl/fixed_partition_fit_allocator_core.sv
// Fixed-partition fit allocator: free-size table in RAM, sequential scan per allocation.
//
//  channel   handshake                     payload
//  -------   ---------------------------   ----------------------------------
//  request   start / busy                  req_item (op, entry_index, amount)
//  result    rsp_valid (one-cycle strobe)  rsp_item (granted, chosen_index,
//                                          remaining_size)
//  config    psel/penable/pwrite, pready   paddr, pwdata, prdata
//
// Load and rejected requests: result the cycle after accept, busy stays low.
// Query: busy while in the query state, which registers the result from the table read.
// Allocate: busy through the scan and write states; the table RAM yields one entry a cycle.
// Reset clears the controller, registers and roving pointer; table entries hold
// nothing until loaded. Results cannot be stalled.
module fixed_partition_fit_allocator_core #(
   parameter int PARTITIONS = fpfa_pkg::PARTITIONS_DEF,
   parameter int SIZE_BITS  = fpfa_pkg::SIZE_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  fpfa_pkg::req_type                   req_item,
   output logic                                rsp_valid,
   output fpfa_pkg::rsp_type                   rsp_item,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [fpfa_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [fpfa_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [fpfa_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready
);

   import fpfa_pkg::*;

   localparam int IDX_W = $clog2(PARTITIONS);
   localparam int CNT_W = $clog2(PARTITIONS + 1);
   localparam int AC_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
   localparam int VAL_W = (SIZE_BITS > AMOUNT_W) ? SIZE_BITS : AMOUNT_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_QUERY,
      ST_SCAN,
      ST_WRITE
   } state_type;

   state_type              state_ff, state_in;
   logic [POLICY_W-1:0]    policy_ff, policy_in;
   logic [COUNT_W-1:0]     count_ff, count_in;
   logic [IDX_W-1:0]       ptr_ff, ptr_in;
   logic [AMOUNT_W-1:0]    amt_ff, amt_in;
   logic [INDEX_W-1:0]     qidx_ff, qidx_in;
   logic [CNT_W-1:0]       act_ff, act_in;
   logic [IDX_W-1:0]       scan_addr_ff, scan_addr_in;
   logic [CNT_W-1:0]       iss_ff, iss_in;
   logic [IDX_W-1:0]       eval_addr_ff, eval_addr_in;
   logic                   pend_ff, pend_in;
   logic                   have_ff, have_in;
   logic [IDX_W-1:0]       pick_ff, pick_in;
   logic [SIZE_BITS-1:0]   best_ff, best_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   logic                   ram_we;
   logic [IDX_W-1:0]       ram_waddr;
   logic [SIZE_BITS-1:0]   ram_wdata;
   logic [IDX_W-1:0]       ram_raddr;
   logic [SIZE_BITS-1:0]   ram_rdata;

   logic                   accept;
   logic                   csr_wr;
   logic                   idx_ok;
   logic [IDX_W-1:0]       req_addr;
   logic [SIZE_BITS-1:0]   ld_val;
   logic [AC_W-1:0]        cnt_ext;
   logic [AC_W-1:0]        cnt_clamp;
   logic [IDX_W-1:0]       start_addr;
   logic [VAL_W-1:0]       d_ext;
   logic [VAL_W-1:0]       amt_ext;
   logic                   fit;
   logic                   seq_policy;
   logic                   better;
   logic                   hit;
   logic                   issue;
   logic [CNT_W-1:0]       addr_inc;
   logic [IDX_W-1:0]       next_addr;
   logic [SIZE_BITS-1:0]   new_val;

   fpfa_ram #(
      .WIDTH (SIZE_BITS),
      .DEPTH (PARTITIONS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // configuration port
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_comb begin
      unique case (paddr[CSR_ADDR_W-1])
         REG_POLICY: prdata = CSR_DATA_W'(policy_ff);
         REG_COUNT:  prdata = CSR_DATA_W'(count_ff);
         default:    prdata = '0;
      endcase
   end

   always_comb begin
      policy_in = policy_ff;
      count_in  = count_ff;
      if (csr_wr) begin
         if (paddr[CSR_ADDR_W-1] == REG_POLICY) begin
            policy_in = pwdata[POLICY_W-1:0];
         end else begin
            count_in = pwdata[COUNT_W-1:0];
         end
      end
   end

   // request decode helpers
   assign accept   = start && (state_ff == ST_IDLE);
   assign idx_ok   = 32'(req_item.entry_index) < 32'(PARTITIONS);
   assign req_addr = IDX_W'(req_item.entry_index);
   assign ld_val   = SIZE_BITS'(req_item.amount);

   always_comb begin
      cnt_ext = AC_W'(count_ff);
      priority if (cnt_ext == '0) begin
         cnt_clamp = AC_W'(1);
      end else if (cnt_ext > AC_W'(PARTITIONS)) begin
         cnt_clamp = AC_W'(PARTITIONS);
      end else begin
         cnt_clamp = cnt_ext;
      end
   end

   // stale pointer restarts the rove at zero
   assign start_addr = ((policy_ff == FIT_NEXT) && (AC_W'(ptr_ff) < cnt_clamp)) ?
                       ptr_ff : '0;

   // scan evaluation on the word read back last cycle
   assign d_ext      = VAL_W'(ram_rdata);
   assign amt_ext    = VAL_W'(amt_ff);
   assign fit        = d_ext >= amt_ext;
   assign seq_policy = (policy_ff == FIT_FIRST) || (policy_ff == FIT_NEXT);
   assign better     = !have_ff ||
                       ((policy_ff == FIT_BEST) ? (d_ext < VAL_W'(best_ff))
                                                : (d_ext > VAL_W'(best_ff)));
   assign hit        = pend_ff && fit && seq_policy;
   assign issue      = (iss_ff < act_ff) && !hit;
   assign addr_inc   = CNT_W'(scan_addr_ff) + CNT_W'(1);
   assign next_addr  = (addr_inc == act_ff) ? '0 : IDX_W'(addr_inc);
   assign new_val    = SIZE_BITS'(VAL_W'(best_ff) - amt_ext);

   assign ram_raddr  = (state_ff == ST_IDLE) ? req_addr : scan_addr_ff;

   always_comb begin
      state_in     = state_ff;
      ptr_in       = ptr_ff;
      amt_in       = amt_ff;
      qidx_in      = qidx_ff;
      act_in       = act_ff;
      scan_addr_in = scan_addr_ff;
      iss_in       = iss_ff;
      eval_addr_in = eval_addr_ff;
      pend_in      = pend_ff;
      have_in      = have_ff;
      pick_in      = pick_ff;
      best_in      = best_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      ram_we       = 1'b0;
      ram_waddr    = req_addr;
      ram_wdata    = ld_val;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_item.op)
                  OP_LOAD: begin
                     rsp_valid_in = 1'b1;
                     if (idx_ok) begin
                        ram_we                = 1'b1;
                        ptr_in                = '0;
                        rsp_in.granted        = 1'b1;
                        rsp_in.chosen_index   = req_item.entry_index;
                        rsp_in.remaining_size = AMOUNT_W'(VAL_W'(ld_val));
                     end
                  end
                  OP_QUERY: begin
                     if (idx_ok) begin
                        qidx_in  = req_item.entry_index;
                        state_in = ST_QUERY;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  OP_ALLOC: begin
                     amt_in       = req_item.amount;
                     act_in       = CNT_W'(cnt_clamp);
                     scan_addr_in = start_addr;
                     iss_in       = '0;
                     pend_in      = 1'b0;
                     have_in      = 1'b0;
                     state_in     = ST_SCAN;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_QUERY: begin
            rsp_valid_in          = 1'b1;
            rsp_in.granted        = 1'b1;
            rsp_in.chosen_index   = qidx_ff;
            rsp_in.remaining_size = AMOUNT_W'(d_ext);
            state_in              = ST_IDLE;
         end
         ST_SCAN: begin
            if (pend_ff && fit && (seq_policy || better)) begin
               have_in = 1'b1;
               pick_in = eval_addr_ff;
               best_in = ram_rdata;
            end
            if (issue) begin
               iss_in       = iss_ff + CNT_W'(1);
               scan_addr_in = next_addr;
               eval_addr_in = scan_addr_ff;
               pend_in      = 1'b1;
            end else begin
               pend_in = 1'b0;
            end
            if (hit || ((iss_ff == act_ff) && !pend_ff)) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            rsp_valid_in = 1'b1;
            if (have_ff) begin
               ram_we                = 1'b1;
               ram_waddr             = pick_ff;
               ram_wdata             = new_val;
               rsp_in.granted        = 1'b1;
               rsp_in.chosen_index   = INDEX_W'(pick_ff);
               rsp_in.remaining_size = AMOUNT_W'(VAL_W'(new_val));
               if (policy_ff == FIT_NEXT) begin
                  ptr_in = pick_ff;
               end
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         policy_ff    <= POLICY_RESET;
         count_ff     <= COUNT_RESET;
         ptr_ff       <= '0;
         pend_ff      <= 1'b0;
         have_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         policy_ff    <= policy_in;
         count_ff     <= count_in;
         ptr_ff       <= ptr_in;
         pend_ff      <= pend_in;
         have_ff      <= have_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      amt_ff       <= amt_in;
      qidx_ff      <= qidx_in;
      act_ff       <= act_in;
      scan_addr_ff <= scan_addr_in;
      iss_ff       <= iss_in;
      eval_addr_ff <= eval_addr_in;
      pick_ff      <= pick_in;
      best_ff      <= best_in;
      rsp_ff       <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

>>> hdl/fpfa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module fpfa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
